>>> rtl/fsv_pkg.sv
// Shared constants, status codes and the result item type for the flash
// record validator. No dependencies; every other file imports this package.
`default_nettype none

package fsv_pkg;

  // Record layout
  localparam int HEADER_BYTES  = 8;
  localparam int ENTRY_BYTES   = 32;
  localparam int COUNT_POS     = 4;   // first rule count byte in the header
  localparam int CRC_POS       = 6;   // first stored CRC byte in the header

  // Limit register
  localparam int LIMIT_W       = 10;
  localparam int MAX_LIMIT     = (1 << LIMIT_W) - 1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  // Byte position must reach the end of the longest accepted record
  localparam int MAX_TOTAL     = HEADER_BYTES + MAX_LIMIT * ENTRY_BYTES;
  localparam int POS_W         = $clog2(MAX_TOTAL + 1);

  // CRC-16/MODBUS, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_LIMIT   = 2'd1,
    STATUS_CRC_BAD = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] sequence_number;
    logic [15:0] entry_count;
  } fsv_result_t;

endpackage

`default_nettype wire

>>> rtl/fsv_crc.sv
// One-byte CRC-16/MODBUS update, purely combinational.
// Depends on fsv_pkg for the polynomial.
`default_nettype none

module fsv_crc (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);
  import fsv_pkg::*;

  logic [15:0] c;

  // Fold the byte in, then shift out eight bits
  always_comb begin
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> rtl/fsv_parser.sv
// Record parser: byte position, header fields, running CRC and parse phase.
// Needs fsv_pkg, fsv_crc; result at record end or on an over-limit count.
`default_nettype none

module fsv_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        record_start,
  input  wire logic [fsv_pkg::LIMIT_W-1:0] max_count,
  output logic                             res_push,
  output fsv_pkg::fsv_result_t             res
);
  import fsv_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  phase_t             phase_r, phase_eff, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_eff, pos_nxt;
  logic [15:0]        crc_r, crc_eff, crc_nxt;
  logic [31:0]        seq_r, seq_eff, seq_nxt;
  logic [15:0]        count_r, count_eff, count_nxt;
  logic [15:0]        stored_r, stored_eff, stored_nxt;
  logic [7:0]         crc_data;
  logic [15:0]        crc_upd;
  logic [POS_W-1:0]   total;
  logic               push;
  status_t            status;

  // A start mark restarts the parse with this byte as header byte 0
  always_comb begin
    if (record_start) begin
      phase_eff  = PH_HEADER;
      pos_eff    = '0;
      crc_eff    = CRC_INIT;
      seq_eff    = '0;
      count_eff  = '0;
      stored_eff = '0;
    end else begin
      phase_eff  = phase_r;
      pos_eff    = pos_r;
      crc_eff    = crc_r;
      seq_eff    = seq_r;
      count_eff  = count_r;
      stored_eff = stored_r;
    end
  end

  // Stored CRC bytes enter the running CRC as zero
  assign crc_data = (phase_eff == PH_HEADER && pos_eff >= POS_W'(CRC_POS)) ? 8'h00 : data_byte;

  fsv_crc u_crc (
    .crc_in  (crc_eff),
    .data_in (crc_data),
    .crc_out (crc_upd)
  );

  // Record length; only counts within the limit reach the data phase
  assign total = POS_W'(HEADER_BYTES)
               + POS_W'(count_eff[LIMIT_W-1:0]) * POS_W'(ENTRY_BYTES);

  // Advance the parse by one byte
  always_comb begin
    phase_nxt  = phase_eff;
    pos_nxt    = pos_eff;
    crc_nxt    = crc_eff;
    seq_nxt    = seq_eff;
    count_nxt  = count_eff;
    stored_nxt = stored_eff;
    push       = 1'b0;
    status     = STATUS_VALID;
    unique case (phase_eff)
      PH_HEADER: begin
        if (pos_eff < POS_W'(COUNT_POS)) begin
          seq_nxt = {seq_eff[23:0], data_byte};
        end else if (pos_eff < POS_W'(CRC_POS)) begin
          count_nxt = {count_eff[7:0], data_byte};
        end else begin
          stored_nxt = {stored_eff[7:0], data_byte};
        end
        crc_nxt = crc_upd;
        pos_nxt = pos_eff + POS_W'(1);
        if (pos_nxt == POS_W'(HEADER_BYTES)) begin
          if (count_nxt > 16'(max_count)) begin
            push      = 1'b1;
            status    = STATUS_LIMIT;
            phase_nxt = PH_IDLE;
          end else if (count_nxt == 16'h0000) begin
            push      = 1'b1;
            status    = (crc_upd == stored_nxt) ? STATUS_VALID : STATUS_CRC_BAD;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        pos_nxt = pos_eff + POS_W'(1);
        if (pos_nxt >= total) begin
          push      = 1'b1;
          status    = (crc_upd == stored_eff) ? STATUS_VALID : STATUS_CRC_BAD;
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        // drop bytes until the next start mark
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Commit the step on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      seq_r    <= '0;
      count_r  <= '0;
      stored_r <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      seq_r    <= seq_nxt;
      count_r  <= count_nxt;
      stored_r <= stored_nxt;
    end
  end

  assign res_push            = take && push;
  assign res.status          = status;
  assign res.sequence_number = seq_nxt;
  assign res.entry_count     = count_nxt;

endmodule

`default_nettype wire

>>> rtl/fsv_out_buf.sv
// Result register with a one-entry skid stage behind it.
// Depends on fsv_pkg for the result item type.
`default_nettype none

module fsv_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire fsv_pkg::fsv_result_t push_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output fsv_pkg::fsv_result_t      out_data,
  output logic                      full
);
  import fsv_pkg::*;

  logic        main_v_r, skid_v_r;
  fsv_result_t main_d_r, skid_d_r;
  logic        pop;

  assign pop = main_v_r && !out_stall;

  // Valid bits: the skid only fills while the result register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // Payload moves with the valid bits
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_d_r <= push_data;
      end else begin
        main_d_r <= push_data;
      end
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_d_r;
  assign full      = skid_v_r;

endmodule

`default_nettype wire

>>> rtl/flash_record_validator.sv
// Top level of the flash record validator: limit register, parser, output buffer.
// Depends on fsv_pkg, fsv_parser (with fsv_crc) and fsv_out_buf.
//
//   channel  ports                                         direction  handshake
//   in       in_data_byte, in_record_start                 input      in_valid / in_stall
//   out      out_status, out_sequence_number, out_entry_count  output  out_valid / out_stall
//   cfg      cfg_max_entry_count                           input      cfg_valid / cfg_ready
//
// One byte is taken every cycle while in_stall is low; the parser updates CRC and header state in a
// single step, and a result item is registered in the result register or its skid stage.
// in_stall rises only when the result register and its skid stage both hold items.
// Reset (rst_n low at a clock edge) sets the limit to 100 and the parser idle.
// cfg_ready is always high; a write takes effect at the edge that accepts it.
`default_nettype none

module flash_record_validator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_record_start,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [31:0]                      out_sequence_number,
  output logic [15:0]                      out_entry_count,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fsv_pkg::LIMIT_W-1:0] cfg_max_entry_count
);
  import fsv_pkg::*;

  logic [LIMIT_W-1:0] max_count_r;
  logic               take;
  logic               res_push;
  logic               buf_full;
  fsv_result_t        res;
  fsv_result_t        out_data;

  assign cfg_ready = 1'b1;

  // Hold the rule count limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_count_r <= cfg_max_entry_count;
    end
  end

  assign in_stall = buf_full;
  assign take     = in_valid && !in_stall;

  fsv_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .data_byte    (in_data_byte),
    .record_start (in_record_start),
    .max_count    (max_count_r),
    .res_push     (res_push),
    .res          (res)
  );

  fsv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign out_status          = out_data.status;
  assign out_sequence_number = out_data.sequence_number;
  assign out_entry_count     = out_data.entry_count;

`ifndef SYNTHESIS
  // Skid stage never holds an item without the result register holding one
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid stage full while result register empty");

  // Input stalls only after the output was stalled with an item waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output back-pressure");

  // Reported status is always one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code on output");

  // A result pushed while the output is stalled and full lands in the skid
  a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && out_valid && out_stall) |=> buf_full)
    else $error("result item lost while output stalled");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for flash_record_validator: directed and random
// settings records, a limit-register schedule and random handshake stalls.
// Depends on fsv_pkg and the flash_record_validator RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsv_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES       = 6;

  typedef enum logic [2:0] {
    PARSE_IDLE   = 3'b001,
    PARSE_HEADER = 3'b010,
    PARSE_DATA   = 3'b100
  } parse_phase_t;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte        = '0;
  logic               in_record_start     = 1'b0;
  logic               out_valid;
  logic               out_stall           = 1'b0;
  logic [1:0]         out_status;
  logic [31:0]        out_sequence_number;
  logic [15:0]        out_entry_count;
  logic               cfg_valid           = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_max_entry_count = '0;

  bit idling    = 1'b1;
  bit hold_now  = 1'b0;

  // Record parser mirror and queue of expected verdicts
  class record_check;
    fsv_result_t        verdict_q[$];
    logic [LIMIT_W-1:0] limit;
    parse_phase_t       phase;
    int unsigned        pos;
    logic [15:0]        crc;
    logic [31:0]        seq;
    logic [15:0]        count;
    logic [15:0]        stored;
    int unsigned        consumed;
    int unsigned        posted;
    int unsigned        checked;
    int unsigned        errors;
    int unsigned        by_status[3];

    function new();
      limit    = LIMIT_RESET;
      phase    = PARSE_IDLE;
      pos      = 0;
      crc      = CRC_INIT;
      seq      = '0;
      count    = '0;
      stored   = '0;
      consumed = 0;
      posted   = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    // Advance a reflected CRC-16/MODBUS by one byte
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void post(status_t s);
      fsv_result_t r;
      r.status          = s;
      r.sequence_number = seq;
      r.entry_count     = count;
      verdict_q.push_back(r);
      posted++;
      by_status[s]++;
      phase = PARSE_IDLE;
    endfunction

    // Consume one accepted item and queue any verdict it completes
    function void note_item(logic [7:0] b, logic st);
      if (st) begin
        pos    = 0;
        crc    = CRC_INIT;
        seq    = '0;
        count  = '0;
        stored = '0;
        phase  = PARSE_HEADER;
      end
      if (phase == PARSE_IDLE) return;
      consumed++;
      if (phase == PARSE_HEADER) begin
        if (pos < COUNT_POS) seq = {seq[23:0], b};
        else if (pos < CRC_POS) count = {count[7:0], b};
        else stored = {stored[7:0], b};
        // stored CRC bytes enter the running CRC as zero
        crc = crc_next(crc, (pos >= CRC_POS) ? 8'h00 : b);
        pos++;
        if (pos >= HEADER_BYTES) begin
          if (count > limit) post(STATUS_LIMIT);
          else if (count == 0) post((crc == stored) ? STATUS_VALID : STATUS_CRC_BAD);
          else phase = PARSE_DATA;
        end
      end else begin
        crc = crc_next(crc, b);
        pos++;
        if (pos >= HEADER_BYTES + count * ENTRY_BYTES)
          post((crc == stored) ? STATUS_VALID : STATUS_CRC_BAD);
      end
    endfunction

    // Compare one accepted result with the oldest verdict
    function void check_result(fsv_result_t got);
      fsv_result_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d seq %h count %0d", $time,
                 got.status, got.sequence_number, got.entry_count);
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.sequence_number !== want.sequence_number) begin
        errors++;
        $display("%0t: sequence number expected %h actual %h", $time,
                 want.sequence_number, got.sequence_number);
      end
      if (got.entry_count !== want.entry_count) begin
        errors++;
        $display("%0t: rule count expected %0d actual %0d", $time,
                 want.entry_count, got.entry_count);
      end
    endfunction
  endclass

  record_check rec_check = new();

  flash_record_validator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_record_start     (in_record_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_sequence_number (out_sequence_number),
    .out_entry_count     (out_entry_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_entry_count (cfg_max_entry_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note accepted items, then check accepted results
  always @(posedge clk) begin : watch_ports
    fsv_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) rec_check.note_item(in_data_byte, in_record_start);
      if (out_valid && !out_stall) begin
        got.status          = status_t'(out_status);
        got.sequence_number = out_sequence_number;
        got.entry_count     = out_entry_count;
        rec_check.check_result(got);
      end
    end
  end

  // Result-side stall: random while idling is set, or a long hold when asked
  initial begin : result_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_now) begin
        hold_now  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idling && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Offer one item, with an occasional gap first, and hold it until taken
  task automatic send_byte(logic [7:0] b, logic st);
    while (idling && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_record_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lay out header, data and a CRC over the record with the CRC bytes zeroed
  function automatic void build_record(logic [31:0] sq, logic [15:0] cnt, int n_data,
                                       bit corrupt, ref logic [7:0] q[$]);
    logic [15:0] c;
    int          idx;
    q = {};
    q.push_back(sq[31:24]);
    q.push_back(sq[23:16]);
    q.push_back(sq[15:8]);
    q.push_back(sq[7:0]);
    q.push_back(cnt[15:8]);
    q.push_back(cnt[7:0]);
    q.push_back(8'h00);
    q.push_back(8'h00);
    for (int i = 0; i < n_data; i++) q.push_back(8'($urandom_range(0, 255)));
    c = CRC_INIT;
    foreach (q[i]) c = record_check::crc_next(c, q[i]);
    q[CRC_POS]     = c[15:8];
    q[CRC_POS + 1] = c[7:0];
    // flip one bit anywhere but the count, which would change the length
    if (corrupt) begin
      idx = $urandom_range(0, q.size() - 1);
      if (idx == COUNT_POS || idx == COUNT_POS + 1) idx = CRC_POS;
      q[idx] ^= 8'(1 << $urandom_range(0, 7));
    end
  endfunction

  task automatic send_bytes(ref logic [7:0] q[$], input int first, input int last);
    for (int i = first; i <= last && i < q.size(); i++) send_byte(q[i], i == 0);
  endtask

  // Send a record; keep > 0 cuts it short after that many bytes
  task automatic send_record(logic [31:0] sq, logic [15:0] cnt, bit corrupt, int keep);
    logic [7:0] q[$];
    int         n_data;
    n_data = (cnt <= rec_check.limit) ? cnt * ENTRY_BYTES : $urandom_range(0, 3);
    build_record(sq, cnt, n_data, corrupt, q);
    send_bytes(q, 0, (keep > 0 && keep < q.size()) ? keep - 1 : q.size() - 1);
  endtask

  task automatic send_noise(int n, bit allow_start);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), allow_start && $urandom_range(0, 9) == 0);
  endtask

  // Drop valid and wait until every verdict has been matched
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rec_check.verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_valid           <= 1'b1;
    cfg_max_entry_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid       <= 1'b0;
    rec_check.limit = v;
  endtask

  // Mostly small counts, with the limit boundary and wide counts mixed in
  function automatic logic [15:0] pick_count();
    int          r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) v = 16'($urandom_range(0, 2));
    else if (r < 70)
      v = (rec_check.limit <= 8) ? 16'(rec_check.limit) : 16'($urandom_range(0, 3));
    else if (r < 85) v = 16'(rec_check.limit) + 16'd1;
    else begin
      v = 16'($urandom_range(0, 65535));
      if (v <= 16'(rec_check.limit)) v = 16'(rec_check.limit) + 16'd1;
    end
    return v;
  endfunction

  task automatic run_records(int budget);
    int stop_at;
    int r;
    stop_at = rec_check.consumed + budget;
    while (rec_check.consumed < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_record($urandom, pick_count(), 1'b0, 0);
      else if (r < 75) send_record($urandom, pick_count(), 1'b1, 0);
      else if (r < 88)
        send_record($urandom, pick_count(), 1'($urandom_range(0, 1)),
                    $urandom_range(1, 40));
      else send_noise($urandom_range(1, 6), 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [7:0] q[$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limit, header-only records, boundaries, restarts
    send_record(32'hFFFF_FFFF, 16'd0, 1'b0, 0);
    send_noise(3, 1'b0);
    send_record(32'h0000_0000, 16'd1, 1'b0, 0);
    send_record(32'h8000_0001, 16'd0, 1'b1, 0);
    send_record(32'h1234_5678, 16'd100, 1'b0, 24);
    send_record(32'hA5A5_5A5A, 16'd101, 1'b0, 0);
    send_record(32'h7FFF_FFFE, 16'hFFFF, 1'b0, 0);
    send_record($urandom, 16'd2, 1'b0, 20);
    send_record($urandom, 16'd1, 1'b0, 5);
    send_record($urandom, 16'd1, 1'b1, 0);
    settle();
    write_limit('0);
    send_record($urandom, 16'd0, 1'b0, 0);
    send_record($urandom, 16'd1, 1'b0, 0);
    settle();
    write_limit(LIMIT_W'(MAX_LIMIT));
    send_record(32'h0F0F_F0F0, 16'(MAX_LIMIT), 1'b0, 40);
    send_record(32'hF0F0_0F0F, 16'(MAX_LIMIT + 1), 1'b0, 0);
    // split a header across a limit write: the value at the last header byte rules
    build_record($urandom, 16'd3, 3 * ENTRY_BYTES, 1'b0, q);
    send_bytes(q, 0, 3);
    settle();
    write_limit(LIMIT_W'(2));
    send_bytes(q, 4, q.size() - 1);

    // Random phases over a schedule of limits
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: write_limit('0);
        1: write_limit(LIMIT_W'(1));
        2: write_limit(LIMIT_W'($urandom_range(2, 8)));
        3: write_limit(LIMIT_RESET);
        4: write_limit(LIMIT_W'(MAX_LIMIT));
        default: write_limit(LIMIT_W'($urandom_range(0, MAX_LIMIT)));
      endcase
      idling = (p != 3);
      // hold the result side while header-only records keep arriving
      if (p == 2) begin
        hold_now = 1'b1;
        repeat (15) send_record($urandom, 16'd0, 1'b0, 0);
      end
      run_records(RANDOM_ITEMS / PHASES);
    end
    settle();

    $display("Covered %0d record bytes and %0d results: %0d valid, %0d over limit, %0d bad CRC.",
             rec_check.consumed, rec_check.checked, rec_check.by_status[STATUS_VALID],
             rec_check.by_status[STATUS_LIMIT], rec_check.by_status[STATUS_CRC_BAD]);
    $display("Limits from 0 to %0d, restarts mid-record and one long result hold were used.",
             MAX_LIMIT);
    if (rec_check.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fsv_pkg.sv
rtl/fsv_crc.sv
rtl/fsv_parser.sv
rtl/fsv_out_buf.sv
rtl/flash_record_validator.sv
tb/sv/tb_top.sv
